### rtl/lsi_pkg.sv
// ----------------------------------------------------------------------------
// LED status indicator package
// Shared widths, register indexes, command codes and types.
// ----------------------------------------------------------------------------
package lsi_pkg;

    localparam int LSI_LEVEL_W  = 16;
    localparam int LSI_COLOUR_W = 8;
    localparam int LSI_INDEX_W  = 3;

    localparam int LSI_QUEUE_DEPTH = 2;

    localparam logic [LSI_INDEX_W-1:0] CFG_FULL_SCALE   = 3'd0;
    localparam logic [LSI_INDEX_W-1:0] CFG_TALK_MIN     = 3'd1;
    localparam logic [LSI_INDEX_W-1:0] CFG_TALK_MAX     = 3'd2;
    localparam logic [LSI_INDEX_W-1:0] CFG_LISTEN_MIN   = 3'd3;
    localparam logic [LSI_INDEX_W-1:0] CFG_LISTEN_MAX   = 3'd4;
    localparam logic [LSI_INDEX_W-1:0] CFG_STBY_PERIOD  = 3'd5;
    localparam logic [LSI_INDEX_W-1:0] CFG_STBY_FLASH   = 3'd6;
    localparam logic [LSI_INDEX_W-1:0] CFG_WAITING      = 3'd7;

    localparam logic [LSI_LEVEL_W-1:0]  RST_FULL_SCALE  = 16'd2000;
    localparam logic [LSI_COLOUR_W-1:0] RST_TALK_MIN    = 8'd8;
    localparam logic [LSI_COLOUR_W-1:0] RST_TALK_MAX    = 8'd30;
    localparam logic [LSI_COLOUR_W-1:0] RST_LISTEN_MIN  = 8'd3;
    localparam logic [LSI_COLOUR_W-1:0] RST_LISTEN_MAX  = 8'd12;
    localparam logic [LSI_LEVEL_W-1:0]  RST_STBY_PERIOD = 16'd100;
    localparam logic [LSI_COLOUR_W-1:0] RST_STBY_FLASH  = 8'd15;
    localparam logic [LSI_COLOUR_W-1:0] RST_WAITING     = 8'd4;

    localparam logic [2:0] MAIN_NONE       = 3'd0;
    localparam logic [2:0] MAIN_BLACK      = 3'd1;
    localparam logic [2:0] MAIN_WAIT_WHITE = 3'd2;
    localparam logic [2:0] MAIN_TALK_RED   = 3'd3;
    localparam logic [2:0] MAIN_TALK_BLUE  = 3'd4;
    localparam logic [2:0] MAIN_LISTEN_RED = 3'd5;

    typedef struct packed {
        logic [LSI_LEVEL_W-1:0]  full_scale_level;
        logic [LSI_COLOUR_W-1:0] talk_min_level;
        logic [LSI_COLOUR_W-1:0] talk_max_level;
        logic [LSI_COLOUR_W-1:0] listen_min_level;
        logic [LSI_COLOUR_W-1:0] listen_max_level;
        logic [LSI_LEVEL_W-1:0]  standby_period;
        logic [LSI_COLOUR_W-1:0] standby_flash_level;
        logic [LSI_COLOUR_W-1:0] waiting_level;
    } cfg_t;

    typedef struct packed {
        logic                   flash;
        logic                   blank;
        logic [2:0]             main_op;
        logic [LSI_LEVEL_W-1:0] level;
    } cmd_t;

endpackage

### rtl/lsi_front.sv
// ----------------------------------------------------------------------------
// LED status indicator front end
// Takes tick transfers, keeps the mode state and turns each tick that needs
// frames into a frame command for the back end.
// ----------------------------------------------------------------------------
module lsi_front
    import lsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   display_off,
    input  logic                   recording,
    input  logic                   playing,
    input  logic                   dialogue,
    input  logic                   listening,
    input  logic [LSI_LEVEL_W-1:0] audio_level,
    output logic                   push_valid,
    input  logic                   push_ready,
    output cmd_t                   push_cmd
);

    logic [LSI_LEVEL_W-1:0] standby_count_reg, standby_count_next;
    logic                   blink_phase_reg, blink_phase_next;
    logic                   led_lit_reg, led_lit_next;
    logic [LSI_LEVEL_W-1:0] count_inc;
    logic                   flash;
    logic                   accept;
    cmd_t                   cmd;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        count_inc = (standby_count_reg != {LSI_LEVEL_W{1'b1}}) ?
                    standby_count_reg + 1'b1 : standby_count_reg;
        flash     = count_inc >= cfg.standby_period;

        standby_count_next = standby_count_reg;
        blink_phase_next   = blink_phase_reg;
        led_lit_next       = led_lit_reg;
        cmd.flash          = 1'b0;
        cmd.blank          = 1'b0;
        cmd.main_op        = MAIN_NONE;
        cmd.level          = audio_level;

        if (display_off)
        begin
            standby_count_next = flash ? '0 : count_inc;
            cmd.flash          = flash;
            cmd.blank          = led_lit_reg;
            led_lit_next       = 1'b0;
        end
        else
        begin
            standby_count_next = '0;
            if (recording)
            begin
                cmd.main_op  = MAIN_TALK_RED;
                led_lit_next = 1'b1;
            end
            else if (playing)
            begin
                cmd.main_op  = MAIN_TALK_BLUE;
                led_lit_next = 1'b1;
            end
            else if (dialogue && !listening)
            begin
                blink_phase_next = !blink_phase_reg;
                cmd.main_op      = blink_phase_reg ? MAIN_BLACK : MAIN_WAIT_WHITE;
                led_lit_next     = 1'b1;
            end
            else if (listening)
            begin
                cmd.main_op  = MAIN_LISTEN_RED;
                led_lit_next = 1'b1;
            end
            else if (led_lit_reg)
            begin
                cmd.main_op  = MAIN_BLACK;
                led_lit_next = 1'b0;
            end
        end
    end

    assign push_cmd   = cmd;
    assign push_valid = accept && (cmd.flash || cmd.blank || (cmd.main_op != MAIN_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            standby_count_reg <= '0;
            blink_phase_reg   <= 1'b0;
            led_lit_reg       <= 1'b0;
        end
        else if (accept)
        begin
            standby_count_reg <= standby_count_next;
            blink_phase_reg   <= blink_phase_next;
            led_lit_reg       <= led_lit_next;
        end
    end

endmodule

### rtl/lsi_queue.sv
// ----------------------------------------------------------------------------
// LED status indicator command queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module lsi_queue
    import lsi_pkg::*;
#(
    parameter int DEPTH = LSI_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/lsi_back.sv
// ----------------------------------------------------------------------------
// LED status indicator back end
// Works out the level brightness with a two-step multiply, a bit-serial divide
// and a bit-serial square root, then sends the frames of each command.
// ----------------------------------------------------------------------------
module lsi_back
    import lsi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  cmd_t                    pop_cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LSI_COLOUR_W-1:0] red,
    output logic [LSI_COLOUR_W-1:0] green,
    output logic [LSI_COLOUR_W-1:0] blue,
    output logic                    last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]              state_reg;
    cmd_t                    cmd_reg;
    logic                    pend_w_reg, pend_k_reg, pend_blank_reg, pend_main_reg;
    logic [3:0]              cnt_reg;
    logic [23:0]             prod_reg;
    logic [LSI_LEVEL_W-1:0]  rem_reg;
    logic [LSI_LEVEL_W-1:0]  shift_reg;
    logic [LSI_LEVEL_W-1:0]  sq_bit_reg;
    logic [LSI_COLOUR_W-1:0] bright_reg;
    logic                    out_valid_reg;
    logic [LSI_COLOUR_W-1:0] red_reg, green_reg, blue_reg;
    logic                    last_reg;

    logic                    is_talk, is_bright, trivial;
    logic [LSI_COLOUR_W-1:0] lo_lvl, hi_lvl, span;
    logic [LSI_LEVEL_W-1:0]  clamp_lvl;
    logic [31:0]             prod_full;
    logic [LSI_LEVEL_W:0]    trial;
    logic                    qbit;
    logic [LSI_LEVEL_W:0]    sq_sum;
    logic                    load;
    logic [LSI_COLOUR_W-1:0] f_red, f_green, f_blue;
    logic                    f_last;

    assign pop_ready = state_reg == ST_IDLE;

    always_comb
    begin
        is_talk   = (cmd_reg.main_op == MAIN_TALK_RED) || (cmd_reg.main_op == MAIN_TALK_BLUE);
        is_bright = is_talk || (cmd_reg.main_op == MAIN_LISTEN_RED);
        lo_lvl    = is_talk ? cfg.talk_min_level : cfg.listen_min_level;
        hi_lvl    = is_talk ? cfg.talk_max_level : cfg.listen_max_level;
        span      = hi_lvl - lo_lvl;
        trivial   = (hi_lvl < lo_lvl) || (cmd_reg.level == '0) ||
                    (cfg.full_scale_level == '0);
        clamp_lvl = (cmd_reg.level > cfg.full_scale_level) ?
                    cfg.full_scale_level : cmd_reg.level;
        prod_full = 32'(prod_reg) * 32'(span);
        trial     = {rem_reg, shift_reg[LSI_LEVEL_W-1]};
        qbit      = trial >= {1'b0, cfg.full_scale_level};
        sq_sum    = {1'b0, rem_reg} + {1'b0, sq_bit_reg};
    end

    always_comb
    begin
        f_red   = '0;
        f_green = '0;
        f_blue  = '0;
        f_last  = 1'b0;
        if (pend_w_reg)
        begin
            f_red   = cfg.standby_flash_level;
            f_green = cfg.standby_flash_level;
            f_blue  = cfg.standby_flash_level;
        end
        else if (pend_k_reg)
        begin
            f_last = !(pend_blank_reg || pend_main_reg);
        end
        else if (pend_blank_reg)
        begin
            f_last = !pend_main_reg;
        end
        else
        begin
            f_last = 1'b1;
            case (cmd_reg.main_op)
                MAIN_WAIT_WHITE:
                begin
                    f_red   = cfg.waiting_level;
                    f_green = cfg.waiting_level;
                    f_blue  = cfg.waiting_level;
                end
                MAIN_TALK_RED:   f_red  = bright_reg;
                MAIN_LISTEN_RED: f_red  = bright_reg;
                MAIN_TALK_BLUE:  f_blue = bright_reg;
                default:         f_red  = '0;
            endcase
        end
    end

    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg <= pop_cmd;
            end
            ST_PREP:
            begin
                prod_reg   <= 24'(clamp_lvl) * 24'(span);
                bright_reg <= lo_lvl;
            end
            ST_MUL:
            begin
                rem_reg   <= prod_full[31:LSI_LEVEL_W];
                shift_reg <= prod_full[LSI_LEVEL_W-1:0];
            end
            ST_DIV:
            begin
                shift_reg <= {shift_reg[LSI_LEVEL_W-2:0], qbit};
                if (cnt_reg == 4'd15)
                begin
                    rem_reg    <= '0;
                    sq_bit_reg <= {2'b01, {(LSI_LEVEL_W-2){1'b0}}};
                end
                else
                begin
                    rem_reg <= qbit ? LSI_LEVEL_W'(trial - {1'b0, cfg.full_scale_level}) :
                               trial[LSI_LEVEL_W-1:0];
                end
            end
            ST_SQRT:
            begin
                if (shift_reg >= sq_sum[LSI_LEVEL_W-1:0] && !sq_sum[LSI_LEVEL_W])
                begin
                    shift_reg <= shift_reg - sq_sum[LSI_LEVEL_W-1:0];
                    rem_reg   <= (rem_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    rem_reg <= rem_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            default:
            begin
                bright_reg <= bright_reg;
            end
        endcase
        if ((state_reg == ST_SQRT) && (cnt_reg == 4'd7))
        begin
            if (shift_reg >= sq_sum[LSI_LEVEL_W-1:0] && !sq_sum[LSI_LEVEL_W])
            begin
                bright_reg <= lo_lvl + LSI_COLOUR_W'((rem_reg >> 1) + sq_bit_reg);
            end
            else
            begin
                bright_reg <= lo_lvl + LSI_COLOUR_W'(rem_reg >> 1);
            end
        end
        if (load)
        begin
            red_reg   <= f_red;
            green_reg <= f_green;
            blue_reg  <= f_blue;
            last_reg  <= f_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_w_reg     <= 1'b0;
            pend_k_reg     <= 1'b0;
            pend_blank_reg <= 1'b0;
            pend_main_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        pend_w_reg     <= pop_cmd.flash;
                        pend_k_reg     <= pop_cmd.flash;
                        pend_blank_reg <= pop_cmd.blank;
                        pend_main_reg  <= pop_cmd.main_op != MAIN_NONE;
                        state_reg      <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= (is_bright && !trivial) ? ST_MUL : ST_EMIT;
                end
                ST_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 4'd15)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    if (cnt_reg == 4'd7)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (load)
                    begin
                        if (pend_w_reg)
                        begin
                            pend_w_reg <= 1'b0;
                        end
                        else if (pend_k_reg)
                        begin
                            pend_k_reg <= 1'b0;
                        end
                        else if (pend_blank_reg)
                        begin
                            pend_blank_reg <= 1'b0;
                        end
                        else
                        begin
                            pend_main_reg <= 1'b0;
                        end
                        if (f_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_div_rem_below_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < cfg.full_scale_level))
        else $error("division remainder not below full scale");

    a_bright_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && is_bright && pend_main_reg) |->
        ((hi_lvl < lo_lvl) ? (bright_reg == lo_lvl) :
         (bright_reg >= lo_lvl && bright_reg <= hi_lvl)))
        else $error("brightness outside the min to max range");

    a_last_frame_ends_command: assert property (@(posedge clk) disable iff (!rst_n)
        (load && f_last) |=> (state_reg == ST_IDLE))
        else $error("command continued after its last frame");

    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |->
        (pend_w_reg || pend_k_reg || pend_blank_reg || pend_main_reg))
        else $error("frame stage entered with nothing to send");
`endif

endmodule

### rtl/led_status_indicator_unit.sv
// ----------------------------------------------------------------------------
// LED status indicator unit
// Turns status ticks into LED colour frames by mode priority.
//
//   Channel   Signals                                        Direction
//   tick      in_valid/in_ready, display_off .. audio_level  in
//   frame     out_valid/out_ready, red, green, blue, last    out
//   config    cfg_write, cfg_index, cfg_data                 in
//
// A tick whose frame needs a brightness passes in the back end through a
// two-step multiply, a serial divide and a serial square root. Other ticks
// go from the prepare step straight to sending their frames.
// Reset clears the mode state, the queue and the output stage; there is no
// clearing pass. The command queue lets ticks be taken while frames stall.
// ----------------------------------------------------------------------------
module led_status_indicator_unit
    import lsi_pkg::*;
#(
    parameter int QUEUE_DEPTH = LSI_QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [LSI_INDEX_W-1:0]  cfg_index,
    input  logic [LSI_LEVEL_W-1:0]  cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    display_off,
    input  logic                    recording,
    input  logic                    playing,
    input  logic                    dialogue,
    input  logic                    listening,
    input  logic [LSI_LEVEL_W-1:0]  audio_level,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [LSI_COLOUR_W-1:0] red,
    output logic [LSI_COLOUR_W-1:0] green,
    output logic [LSI_COLOUR_W-1:0] blue,
    output logic                    last
);

    cfg_t cfg_reg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale_level    <= RST_FULL_SCALE;
            cfg_reg.talk_min_level      <= RST_TALK_MIN;
            cfg_reg.talk_max_level      <= RST_TALK_MAX;
            cfg_reg.listen_min_level    <= RST_LISTEN_MIN;
            cfg_reg.listen_max_level    <= RST_LISTEN_MAX;
            cfg_reg.standby_period      <= RST_STBY_PERIOD;
            cfg_reg.standby_flash_level <= RST_STBY_FLASH;
            cfg_reg.waiting_level       <= RST_WAITING;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FULL_SCALE:  cfg_reg.full_scale_level    <= cfg_data;
                CFG_TALK_MIN:    cfg_reg.talk_min_level      <= cfg_data[LSI_COLOUR_W-1:0];
                CFG_TALK_MAX:    cfg_reg.talk_max_level      <= cfg_data[LSI_COLOUR_W-1:0];
                CFG_LISTEN_MIN:  cfg_reg.listen_min_level    <= cfg_data[LSI_COLOUR_W-1:0];
                CFG_LISTEN_MAX:  cfg_reg.listen_max_level    <= cfg_data[LSI_COLOUR_W-1:0];
                CFG_STBY_PERIOD: cfg_reg.standby_period      <= cfg_data;
                CFG_STBY_FLASH:  cfg_reg.standby_flash_level <= cfg_data[LSI_COLOUR_W-1:0];
                CFG_WAITING:     cfg_reg.waiting_level       <= cfg_data[LSI_COLOUR_W-1:0];
                default:         cfg_reg.waiting_level       <= cfg_reg.waiting_level;
            endcase
        end
    end

    lsi_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .display_off    (display_off),
        .recording      (recording),
        .playing        (playing),
        .dialogue       (dialogue),
        .listening      (listening),
        .audio_level    (audio_level),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    lsi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    lsi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last)
    );

endmodule

### bench/led_status_indicator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED status indicator unit testbench
// Sends status ticks through the valid/ready tick channel and checks every
// LED frame against a cycle-free model of the mode priority, the standby
// counter, the waiting blink and the square-root brightness. Directed ticks
// cover the mode corners and register extremes; random phases with fresh
// register settings, random idling on both sides and a long frame stall follow.
// ----------------------------------------------------------------------------
module led_status_indicator_unit_tb;
    import lsi_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic                   off;
        logic                   rec;
        logic                   play;
        logic                   conv;
        logic                   listen;
        logic [LSI_LEVEL_W-1:0] level;
    } tick_t;

    typedef struct packed {
        logic [LSI_COLOUR_W-1:0] red;
        logic [LSI_COLOUR_W-1:0] green;
        logic [LSI_COLOUR_W-1:0] blue;
        logic                    last;
    } frame_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [LSI_INDEX_W-1:0]  cfg_index;
    logic [LSI_LEVEL_W-1:0]  cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    display_off;
    logic                    recording;
    logic                    playing;
    logic                    dialogue;
    logic                    listening;
    logic [LSI_LEVEL_W-1:0]  audio_level;
    logic                    out_valid;
    logic                    out_ready;
    logic [LSI_COLOUR_W-1:0] red;
    logic [LSI_COLOUR_W-1:0] green;
    logic [LSI_COLOUR_W-1:0] blue;
    logic                    last;

    cfg_t                   regs;
    logic [LSI_LEVEL_W-1:0] standby_ticks;
    logic                   blink_on;
    logic                   led_on;
    frame_t                 frames_due[$];
    int                     mismatches;
    int                     quiet_cycles;
    int                     hold_left;
    bit                     steady;

    led_status_indicator_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .display_off    (display_off),
        .recording      (recording),
        .playing        (playing),
        .dialogue       (dialogue),
        .listening      (listening),
        .audio_level    (audio_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    function automatic logic [7:0] scaled_brightness(input logic [15:0] level,
                                                     input logic [7:0] lo,
                                                     input logic [7:0] hi);
        logic [15:0] lvl;
        logic [7:0]  span;
        logic [47:0] energy;
        logic [15:0] root;
        logic [15:0] trial;
        if (hi < lo || level == 16'd0 || regs.full_scale_level == 16'd0)
            return lo;
        lvl = (level > regs.full_scale_level) ? regs.full_scale_level : level;
        span = hi - lo;
        energy = (48'(lvl) * span * span) / regs.full_scale_level;
        root = 16'd0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (16'd1 << b);
            if (48'(trial) * trial <= energy)
                root = trial;
        end
        return lo + root[7:0];
    endfunction

    function automatic void predict_tick(input tick_t t);
        frame_t      burst[$];
        logic [7:0]  lum;
        logic [7:0]  w;
        if (t.off)
        begin
            if (standby_ticks != 16'hFFFF)
                standby_ticks++;
            if (standby_ticks >= regs.standby_period)
            begin
                w = regs.standby_flash_level;
                standby_ticks = 16'd0;
                burst.push_back({w, w, w, 1'b0});
                burst.push_back('0);
            end
            if (led_on)
            begin
                burst.push_back('0);
                led_on = 1'b0;
            end
        end
        else
        begin
            standby_ticks = 16'd0;
            if (t.rec)
            begin
                lum = scaled_brightness(t.level, regs.talk_min_level, regs.talk_max_level);
                burst.push_back({lum, 8'd0, 8'd0, 1'b0});
                led_on = 1'b1;
            end
            else if (t.play)
            begin
                lum = scaled_brightness(t.level, regs.talk_min_level, regs.talk_max_level);
                burst.push_back({8'd0, 8'd0, lum, 1'b0});
                led_on = 1'b1;
            end
            else if (t.conv && !t.listen)
            begin
                blink_on = ~blink_on;
                w = blink_on ? regs.waiting_level : 8'd0;
                burst.push_back({w, w, w, 1'b0});
                led_on = 1'b1;
            end
            else if (t.listen)
            begin
                lum = scaled_brightness(t.level, regs.listen_min_level,
                                        regs.listen_max_level);
                burst.push_back({lum, 8'd0, 8'd0, 1'b0});
                led_on = 1'b1;
            end
            else if (led_on)
            begin
                burst.push_back('0);
                led_on = 1'b0;
            end
        end
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[i])
            frames_due.push_back(burst[i]);
    endfunction

    function automatic int pick_gap();
        int g;
        g = 0;
        if (!steady)
            while (g < 20 && $urandom_range(0, 99) < 35)
                g++;
        return g;
    endfunction

    function automatic tick_t mk_tick(input int off, input int rec, input int play,
                                      input int conv, input int listen,
                                      input logic [15:0] level);
        return {1'(off), 1'(rec), 1'(play), 1'(conv), 1'(listen), level};
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    kind;
        int    lv;
        t.off    = 1'b0;
        t.rec    = 1'($urandom_range(0, 1));
        t.play   = 1'($urandom_range(0, 1));
        t.conv   = 1'($urandom_range(0, 1));
        t.listen = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 99);
        if (kind < 25)
            t.off = 1'b1;
        else if (kind < 40)
            t.rec = 1'b1;
        else if (kind < 55)
        begin
            t.rec  = 1'b0;
            t.play = 1'b1;
        end
        else if (kind < 70)
        begin
            t.rec    = 1'b0;
            t.play   = 1'b0;
            t.conv   = 1'b1;
            t.listen = 1'b0;
        end
        else if (kind < 85)
        begin
            t.rec    = 1'b0;
            t.play   = 1'b0;
            t.listen = 1'b1;
        end
        else
        begin
            t.rec    = 1'b0;
            t.play   = 1'b0;
            t.conv   = 1'b0;
            t.listen = 1'b0;
        end
        lv = $urandom_range(0, 7);
        if (lv == 0)
            t.level = 16'd0;
        else if (lv == 1)
            t.level = 16'hFFFF;
        else if (lv < 4)
            t.level = regs.full_scale_level + 16'($urandom_range(0, 8)) - 16'd4;
        else
            t.level = 16'($urandom);
        return t;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        int   pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.full_scale_level = 16'd0;
        else if (pick == 1)
            s.full_scale_level = 16'hFFFF;
        else if (pick == 2)
            s.full_scale_level = 16'd1;
        else
            s.full_scale_level = 16'($urandom_range(1, 4000));
        s.talk_min_level      = 8'($urandom_range(0, 128));
        s.talk_max_level      = 8'($urandom_range(0, 255));
        s.listen_min_level    = 8'($urandom_range(0, 128));
        s.listen_max_level    = 8'($urandom_range(0, 255));
        s.standby_period      = ($urandom_range(0, 7) == 0) ? 16'd0 :
                                16'($urandom_range(1, 6));
        s.standby_flash_level = 8'($urandom);
        s.waiting_level       = 8'($urandom);
        return s;
    endfunction

    task automatic put_reg(input logic [LSI_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Upper data bits of the narrow registers carry junk that must be ignored.
    task automatic set_regs(input cfg_t s);
        regs = s;
        put_reg(CFG_FULL_SCALE, s.full_scale_level);
        put_reg(CFG_TALK_MIN, {8'($urandom), s.talk_min_level});
        put_reg(CFG_TALK_MAX, {8'($urandom), s.talk_max_level});
        put_reg(CFG_LISTEN_MIN, {8'($urandom), s.listen_min_level});
        put_reg(CFG_LISTEN_MAX, {8'($urandom), s.listen_max_level});
        put_reg(CFG_STBY_PERIOD, s.standby_period);
        put_reg(CFG_STBY_FLASH, {8'($urandom), s.standby_flash_level});
        put_reg(CFG_WAITING, {8'($urandom), s.waiting_level});
        cfg_write <= 1'b0;
    endtask

    task automatic send_tick(input tick_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        display_off    <= t.off;
        recording      <= t.rec;
        playing        <= t.play;
        dialogue       <= t.conv;
        listening      <= t.listen;
        audio_level    <= t.level;
        do
            @(posedge clk);
        while (!in_ready);
        predict_tick(t);
    endtask

    // A tick may leave no frame while the back end is still busy, hence the settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_tick(mk_tick(0, 0, 0, 0, 0, 16'd500));
        send_tick(mk_tick(0, 1, 0, 0, 0, 16'd0));
        send_tick(mk_tick(0, 1, 1, 1, 1, 16'd2000));
        send_tick(mk_tick(0, 0, 1, 1, 0, 16'hFFFF));
        send_tick(mk_tick(0, 0, 0, 1, 0, 16'd77));
        send_tick(mk_tick(0, 0, 0, 1, 0, 16'd77));
        send_tick(mk_tick(0, 0, 0, 0, 1, 16'd1000));
        send_tick(mk_tick(0, 0, 0, 0, 0, 16'd0));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        send_tick(mk_tick(0, 0, 0, 1, 1, 16'd0));
        send_tick(mk_tick(1, 1, 1, 1, 1, 16'hFFFF));
        drain();
    endtask

    task automatic test_register_extremes();
        set_regs('{full_scale_level: 16'hFFFF, talk_min_level: 8'd0,
                   talk_max_level: 8'd255, listen_min_level: 8'd255,
                   listen_max_level: 8'd0, standby_period: 16'd1,
                   standby_flash_level: 8'd255, waiting_level: 8'd255});
        send_tick(mk_tick(0, 1, 0, 0, 0, 16'hFFFF));
        send_tick(mk_tick(0, 0, 1, 0, 0, 16'd1));
        send_tick(mk_tick(0, 0, 0, 0, 1, 16'hFFFF));
        send_tick(mk_tick(0, 0, 0, 1, 0, 16'h5555));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'hAAAA));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        drain();
    endtask

    task automatic test_standby_period();
        set_regs('{full_scale_level: 16'd0, talk_min_level: 8'd255,
                   talk_max_level: 8'd255, listen_min_level: 8'd0,
                   listen_max_level: 8'd0, standby_period: 16'd0,
                   standby_flash_level: 8'hAA, waiting_level: 8'h55});
        send_tick(mk_tick(0, 1, 0, 0, 0, 16'd1234));
        send_tick(mk_tick(0, 0, 0, 0, 1, 16'h8000));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        drain();
        set_regs('{full_scale_level: 16'd2000, talk_min_level: 8'd8,
                   talk_max_level: 8'd30, listen_min_level: 8'd3,
                   listen_max_level: 8'd12, standby_period: 16'hFFFF,
                   standby_flash_level: 8'd15, waiting_level: 8'd4});
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        drain();
        // The count already lies above the lowered period, so the next tick flashes.
        regs.standby_period = 16'd2;
        put_reg(CFG_STBY_PERIOD, 16'd2);
        cfg_write <= 1'b0;
        send_tick(mk_tick(1, 0, 0, 0, 0, 16'd0));
        drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 5; p++)
        begin
            steady = (p == 2);
            set_regs(random_settings());
            repeat (15) send_tick(random_tick());
            drain();
        end
        steady = 1'b0;
    endtask

    task automatic test_frame_stall();
        steady = 1'b1;
        hold_left = HOLD_CYCLES;
        repeat (12) send_tick(random_tick());
        steady = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        display_off    <= 1'b0;
        recording      <= 1'b0;
        playing        <= 1'b0;
        dialogue       <= 1'b0;
        listening      <= 1'b0;
        audio_level    <= '0;
        mismatches     = 0;
        hold_left      = 0;
        steady         = 1'b0;
        regs = '{full_scale_level: RST_FULL_SCALE, talk_min_level: RST_TALK_MIN,
                 talk_max_level: RST_TALK_MAX, listen_min_level: RST_LISTEN_MIN,
                 listen_max_level: RST_LISTEN_MAX, standby_period: RST_STBY_PERIOD,
                 standby_flash_level: RST_STBY_FLASH, waiting_level: RST_WAITING};
        standby_ticks = 16'd0;
        blink_on      = 1'b0;
        led_on        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_register_extremes();
        test_standby_period();
        test_random_phases();
        test_frame_stall();
        if (frames_due.size() != 0)
            flag_mismatch("frames never delivered", 0, frames_due.size());
        if (mismatches == 0)
            $display("led_status_indicator_unit_tb passed");
        else
            $display("led_status_indicator_unit_tb failed");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {red, green, blue, last};
            if (frames_due.size() == 0)
                flag_mismatch("frame transfer with nothing outstanding", 0, 1);
            else
            begin
                want = frames_due.pop_front();
                if (got.red !== want.red)
                    flag_mismatch("red", want.red, got.red);
                if (got.green !== want.green)
                    flag_mismatch("green", want.green, got.green);
                if (got.blue !== want.blue)
                    flag_mismatch("blue", want.blue, got.blue);
                if (got.last !== want.last)
                    flag_mismatch("last", want.last, got.last);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("led_status_indicator_unit_tb failed");
                $finish;
            end
        end
    end

endmodule
